// File: design/rdss_pkg.sv
// Shared types, constants and the glyph table of the radix digit scan unit.
package rdss_pkg;

    localparam int DIGITS_DEFAULT      = 4;
    localparam int SAMPLE_BITS_DEFAULT = 10;
    localparam int DIGIT_W             = 4;
    localparam int RADIX_W             = 5;
    localparam int ENABLE_W            = 4;
    localparam int SEGMENTS_W          = 8;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    typedef logic [DIGIT_W-1:0]    digit_t;
    typedef logic [RADIX_W-1:0]    radix_t;
    typedef logic [SEGMENTS_W-1:0] segments_t;
    typedef logic [ENABLE_W-1:0]   enable_t;

    // Active-high segment patterns for the hexadecimal glyphs 0 to F.
    function automatic segments_t glyph(input digit_t d);
        segments_t s;
        unique case (d)
            4'h0: s = 8'h3F;
            4'h1: s = 8'h06;
            4'h2: s = 8'h5B;
            4'h3: s = 8'h4F;
            4'h4: s = 8'h66;
            4'h5: s = 8'h6D;
            4'h6: s = 8'h7D;
            4'h7: s = 8'h07;
            4'h8: s = 8'h7F;
            4'h9: s = 8'h6F;
            4'hA: s = 8'h77;
            4'hB: s = 8'h7C;
            4'hC: s = 8'h58;
            4'hD: s = 8'h5E;
            4'hE: s = 8'h79;
            default: s = 8'h71;
        endcase
        return s;
    endfunction

endpackage

// File: design/rdss_if.sv
// Channel interfaces of the radix digit scan unit: samples, digit results and radix writes.
interface rdss_sample_if #(
    parameter int SAMPLE_BITS = rdss_pkg::SAMPLE_BITS_DEFAULT
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface rdss_digit_if;
    logic                valid;
    logic                ready;
    rdss_pkg::enable_t   digit_enable;
    rdss_pkg::segments_t segments;
    logic                last_digit;

    modport source (output valid, output digit_enable, output segments, output last_digit,
                    input ready);
    modport sink   (input valid, input digit_enable, input segments, input last_digit,
                    output ready);
endinterface

interface rdss_cfg_if;
    logic             valid;
    logic             ready;
    rdss_pkg::radix_t radix;

    modport source (output valid, output radix, input ready);
    modport sink   (input valid, input radix, output ready);
endinterface

// File: design/radix_digits_to_seven_segment_scan_unit.sv
// Top level of the radix digit scan unit: radix register, cell pipeline and output register.
//
//   Channel    Role    Payload
//   sample_ch  sink    sample [SAMPLE_BITS-1:0]
//   digit_ch   source  digit_enable [3:0], segments [7:0], last_digit
//   cfg_ch     sink    radix [4:0], always ready
//
// Each sample passes through SAMPLE_BITS pipeline stages, one sample bit per stage,
// so its first digit is offered once the output register has loaded it.
// The output register sends a sample's DIGITS results in turn; a new one loads as the last goes.
// The whole pipeline holds while its last stage is full and the output register cannot take it.
// Reset clears all valid flags and sets the radix to ten.
module radix_digits_to_seven_segment_scan_unit #(
    parameter int DIGITS      = rdss_pkg::DIGITS_DEFAULT,
    parameter int SAMPLE_BITS = rdss_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    rdss_sample_if.sink  sample_ch,
    rdss_digit_if.source digit_ch,
    rdss_cfg_if.sink     cfg_ch
);
    import rdss_pkg::*;

    radix_t                   radix_reg;
    radix_t                   radix_eff;
    logic                     en;
    logic                     can_load;
    logic                     stage_valid  [SAMPLE_BITS+1];
    digit_t [DIGITS-1:0]      stage_digits [SAMPLE_BITS+1];
    logic   [SAMPLE_BITS-1:0] stage_bits   [SAMPLE_BITS];

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (cfg_ch.valid)
        begin
            radix_reg <= cfg_ch.radix;
        end
    end

    always_comb
    begin
        if (radix_reg < RADIX_MIN)
        begin
            radix_eff = RADIX_MIN;
        end
        else if (radix_reg > RADIX_MAX)
        begin
            radix_eff = RADIX_MAX;
        end
        else
        begin
            radix_eff = radix_reg;
        end
    end

    assign en              = !stage_valid[SAMPLE_BITS] || can_load;
    assign sample_ch.ready = en;

    assign stage_valid[0]  = sample_ch.valid;
    assign stage_digits[0] = '0;
    assign stage_bits[0]   = sample_ch.sample;

    for (genvar k = 0; k < SAMPLE_BITS; k++)
    begin : g_stage
        if (k < SAMPLE_BITS - 1)
        begin : g_mid
            rdss_stage #(
                .DIGITS      (DIGITS),
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_stage (
                .clk        (clk),
                .rst_n      (rst_n),
                .en         (en),
                .radix      (radix_eff),
                .valid_in   (stage_valid[k]),
                .digits_in  (stage_digits[k]),
                .bits_in    (stage_bits[k]),
                .valid_out  (stage_valid[k+1]),
                .digits_out (stage_digits[k+1]),
                .bits_out   (stage_bits[k+1])
            );
        end
        else
        begin : g_end
            rdss_stage #(
                .DIGITS      (DIGITS),
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_stage (
                .clk        (clk),
                .rst_n      (rst_n),
                .en         (en),
                .radix      (radix_eff),
                .valid_in   (stage_valid[k]),
                .digits_in  (stage_digits[k]),
                .bits_in    (stage_bits[k]),
                .valid_out  (stage_valid[k+1]),
                .digits_out (stage_digits[k+1]),
                .bits_out   ()
            );
        end
    end

    rdss_serializer #(
        .DIGITS (DIGITS)
    ) u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (stage_valid[SAMPLE_BITS]),
        .digits_in  (stage_digits[SAMPLE_BITS]),
        .can_load   (can_load),
        .digit_ch   (digit_ch)
    );

endmodule

// File: design/rdss_cell.sv
// One digit cell: doubles its digit, adds the incoming carry and reduces modulo the radix.
module rdss_cell (
    input  rdss_pkg::radix_t radix,
    input  rdss_pkg::digit_t digit_in,
    input  logic             carry_in,
    output rdss_pkg::digit_t digit_out,
    output logic             carry_out
);
    import rdss_pkg::*;

    radix_t doubled;

    always_comb
    begin
        doubled = {digit_in, carry_in};
        if (doubled >= radix)
        begin
            digit_out = DIGIT_W'(doubled - radix);
            carry_out = 1'b1;
        end
        else
        begin
            digit_out = doubled[DIGIT_W-1:0];
            carry_out = 1'b0;
        end
    end

endmodule

// File: design/rdss_stage.sv
// One pipeline stage: a row of digit cells that shifts one sample bit into the digits.
module rdss_stage #(
    parameter int DIGITS      = rdss_pkg::DIGITS_DEFAULT,
    parameter int SAMPLE_BITS = rdss_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  rdss_pkg::radix_t                     radix,
    input  logic                                 valid_in,
    input  rdss_pkg::digit_t [DIGITS-1:0]        digits_in,
    input  logic             [SAMPLE_BITS-1:0]   bits_in,
    output logic                                 valid_out,
    output rdss_pkg::digit_t [DIGITS-1:0]        digits_out,
    output logic             [SAMPLE_BITS-1:0]   bits_out
);
    import rdss_pkg::*;

    logic                          valid_reg;
    digit_t [DIGITS-1:0]           digits_reg;
    digit_t [DIGITS-1:0]           digits_next;
    logic   [SAMPLE_BITS-1:0]      bits_reg;
    logic   [DIGITS:0]             carry;

    assign carry[0] = bits_in[SAMPLE_BITS-1];

    for (genvar i = 0; i < DIGITS; i++)
    begin : g_cell
        rdss_cell u_cell (
            .radix     (radix),
            .digit_in  (digits_in[i]),
            .carry_in  (carry[i]),
            .digit_out (digits_next[i]),
            .carry_out (carry[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            digits_reg <= digits_next;
            bits_reg   <= {bits_in[SAMPLE_BITS-2:0], 1'b0};
        end
    end

    assign valid_out  = valid_reg;
    assign digits_out = digits_reg;
    assign bits_out   = bits_reg;

endmodule

// File: design/rdss_serializer.sv
// Output register that hands out the digits of one sample, least significant first.
module rdss_serializer #(
    parameter int DIGITS = rdss_pkg::DIGITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load_valid,
    input  rdss_pkg::digit_t [DIGITS-1:0] digits_in,
    output logic                          can_load,
    rdss_digit_if.source                  digit_ch
);
    import rdss_pkg::*;

    localparam int POS_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(DIGITS - 1);

    logic                busy_reg;
    logic                busy_next;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    digit_t [DIGITS-1:0] digits_reg;
    digit_t [DIGITS-1:0] digits_next;
    logic                transfer;
    logic                load;

    assign transfer = busy_reg && digit_ch.ready;
    assign can_load = !busy_reg || (digit_ch.ready && pos_reg == POS_LAST);
    assign load     = load_valid && can_load;

    always_comb
    begin
        busy_next   = busy_reg;
        pos_next    = pos_reg;
        digits_next = digits_reg;
        if (load)
        begin
            busy_next   = 1'b1;
            pos_next    = '0;
            digits_next = digits_in;
        end
        else if (transfer)
        begin
            if (pos_reg == POS_LAST)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pos_next    = pos_reg + 1'b1;
                digits_next = digits_reg >> DIGIT_W;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
    end

    assign digit_ch.valid        = busy_reg;
    assign digit_ch.digit_enable = enable_t'(1) << pos_reg;
    assign digit_ch.segments     = glyph(digits_reg[0]);
    assign digit_ch.last_digit   = (pos_reg == POS_LAST);

endmodule
